FILE: hw/rtl/sv39_ptw_pkg.sv
// Shared constants for the Sv39 page-table walker: widths, entry format,
// status codes, item and register codes. No dependencies.
package sv39_ptw_pkg;

  // Store geometry
  localparam int unsigned POOL_PAGES_DEF   = 64;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned IDX_W            = 9;

  // Field widths
  localparam int unsigned PPN_W   = 44;
  localparam int unsigned PTE_W   = 64;
  localparam int unsigned VA_W    = 39;
  localparam int unsigned PA_W    = 56;
  localparam int unsigned EIDX_W  = 15;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned CFG_IDX_W = 8;

  // Entry format
  localparam int unsigned PTE_V_BIT   = 0;
  localparam int unsigned PTE_U_BIT   = 4;
  localparam int unsigned PTE_PPN_LSB = 10;

  // Virtual address bit that marks an address of 2^38 or more
  localparam int unsigned VA_HIGH_BIT = 38;

  // Walk levels
  localparam logic [1:0] LVL_ROOT = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  // Item codes
  localparam logic FUNC_WRITE     = 1'b0;
  localparam logic FUNC_TRANSLATE = 1'b1;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_HIGH    = 3'd1;
  localparam logic [ST_W-1:0] ST_NOMID   = 3'd2;
  localparam logic [ST_W-1:0] ST_BADLEAF = 3'd3;
  localparam logic [ST_W-1:0] ST_NOUSER  = 3'd4;
  localparam logic [ST_W-1:0] ST_OUTSIDE = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PPN     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_USER = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_OFFSET   = 8'd3;

endpackage

FILE: hw/rtl/sv39_page_table_walker_top.sv
// Sv39 page-table walker top level: table store, walk sequencer, config regs.
// Depends on sv39_ptw_pkg.
//
// Usage: after reset the block clears its table store, one entry per cycle,
// with busy high; config writes are taken throughout. An item is taken when
// start is high and busy is low. A write item stores its entry if the index
// lies inside the store and returns its word (zero address, status ok) in
// the next cycle; busy stays low. A translate item walks the table through
// the store: each level runs a page range check and read issue, then an
// entry check on the registered read data; a full walk returns its word
// after the leaf check, an address of 2^38 or more returns in the next
// cycle, and a fault at a higher level returns early. Each result word is
// shown for exactly one cycle on out_strobe and must be taken then; it cannot
// be held off.
module sv39_page_table_walker_top #(
  parameter int unsigned POOL_PAGES = sv39_ptw_pkg::POOL_PAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // item channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_func,
  input  logic [sv39_ptw_pkg::EIDX_W-1:0]        in_entry_index,
  input  logic [sv39_ptw_pkg::PTE_W-1:0]         in_pte_value,
  input  logic [sv39_ptw_pkg::VA_W-1:0]          in_virt_addr,
  // result channel
  output logic                                   out_strobe,
  output logic [sv39_ptw_pkg::PA_W-1:0]          out_phys_addr,
  output logic [sv39_ptw_pkg::ST_W-1:0]          out_status,
  // config channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sv39_ptw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sv39_ptw_pkg::PPN_W-1:0]         cfg_data
);

  localparam int unsigned DEPTH = POOL_PAGES * sv39_ptw_pkg::ENTRIES_PER_PAGE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PPN_W = sv39_ptw_pkg::PPN_W;
  localparam int unsigned PTE_W = sv39_ptw_pkg::PTE_W;
  localparam int unsigned IDX_W = sv39_ptw_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_EVAL
  } state_t;

  // ------------------------------------------------------------------
  // Registers
  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   clr_addr_r, clr_addr_nxt;
  logic [1:0]                      lvl_r, lvl_nxt;
  logic [PPN_W-1:0]                cur_ppn_r, cur_ppn_nxt;
  logic [sv39_ptw_pkg::VA_W-1:0]   va_r, va_nxt;
  logic                            strobe_r, strobe_nxt;
  logic [sv39_ptw_pkg::PA_W-1:0]   pa_r, pa_nxt;
  logic [sv39_ptw_pkg::ST_W-1:0]   st_r, st_nxt;

  logic [PPN_W-1:0]                root_ppn_r;
  logic [PPN_W-1:0]                pool_base_r;
  logic                            req_user_r;
  logic                            add_off_r;

  logic [PTE_W-1:0]                mem [DEPTH];
  logic [PTE_W-1:0]                rd_data_r;

  // Memory port control
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [PTE_W-1:0]                mem_wdata;
  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;

  // Shared page-range unit
  logic [PPN_W:0]                  page_diff;
  logic                            page_outside;
  logic [IDX_W-1:0]                lvl_idx;

  logic                            accept;
  logic                            wr_in_range;

  assign accept      = start && !busy;
  assign busy        = (state_r != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign wr_in_range = (32'(in_entry_index) < 32'(DEPTH));

  // 9-bit table index for the current level
  always_comb begin
    unique case (lvl_r)
      2'd2:    lvl_idx = va_r[38:30];
      2'd1:    lvl_idx = va_r[29:21];
      default: lvl_idx = va_r[20:12];
    endcase
  end

  // Page number relative to the store base, with range check
  assign page_diff    = {1'b0, cur_ppn_r} - {1'b0, pool_base_r};
  assign page_outside = page_diff[PPN_W] ||
                        (page_diff[PPN_W-1:0] >= PPN_W'(POOL_PAGES));

  // Memory port: clearing pass or item write; reads only during a walk
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && (in_func == sv39_ptw_pkg::FUNC_WRITE) && wr_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(in_entry_index);
      mem_wdata = in_pte_value;
    end
  end

  assign mem_re    = (state_r == S_ADDR) && !page_outside;
  assign mem_raddr = AW'({page_diff[PPN_W-1:0], lvl_idx});

  // Table store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_ppn_r  <= '0;
      pool_base_r <= '0;
      req_user_r  <= 1'b1;
      add_off_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sv39_ptw_pkg::CFG_ROOT_PPN:     root_ppn_r  <= cfg_data;
        sv39_ptw_pkg::CFG_POOL_BASE:    pool_base_r <= cfg_data;
        sv39_ptw_pkg::CFG_REQUIRE_USER: req_user_r  <= cfg_data[0];
        sv39_ptw_pkg::CFG_ADD_OFFSET:   add_off_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Walk sequencer next state
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    lvl_nxt      = lvl_r;
    cur_ppn_nxt  = cur_ppn_r;
    va_nxt       = va_r;
    strobe_nxt   = 1'b0;
    pa_nxt       = pa_r;
    st_nxt       = st_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (in_func == sv39_ptw_pkg::FUNC_WRITE) begin
            strobe_nxt = 1'b1;
            pa_nxt     = '0;
            st_nxt     = sv39_ptw_pkg::ST_OK;
          end else if (in_virt_addr[sv39_ptw_pkg::VA_HIGH_BIT]) begin
            strobe_nxt = 1'b1;
            pa_nxt     = '0;
            st_nxt     = sv39_ptw_pkg::ST_HIGH;
          end else begin
            va_nxt      = in_virt_addr;
            cur_ppn_nxt = root_ppn_r;
            lvl_nxt     = sv39_ptw_pkg::LVL_ROOT;
            state_nxt   = S_ADDR;
          end
        end
      end

      // Range check and read issue
      S_ADDR: begin
        if (page_outside) begin
          strobe_nxt = 1'b1;
          pa_nxt     = '0;
          st_nxt     = sv39_ptw_pkg::ST_OUTSIDE;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_EVAL;
        end
      end

      // Entry check on the read word
      S_EVAL: begin
        if (!rd_data_r[sv39_ptw_pkg::PTE_V_BIT]) begin
          strobe_nxt = 1'b1;
          pa_nxt     = '0;
          st_nxt     = (lvl_r != sv39_ptw_pkg::LVL_LEAF) ? sv39_ptw_pkg::ST_NOMID
                                                         : sv39_ptw_pkg::ST_BADLEAF;
          state_nxt  = S_IDLE;
        end else if ((lvl_r == sv39_ptw_pkg::LVL_LEAF) && req_user_r &&
                     !rd_data_r[sv39_ptw_pkg::PTE_U_BIT]) begin
          strobe_nxt = 1'b1;
          pa_nxt     = '0;
          st_nxt     = sv39_ptw_pkg::ST_NOUSER;
          state_nxt  = S_IDLE;
        end else begin
          cur_ppn_nxt = rd_data_r[sv39_ptw_pkg::PTE_PPN_LSB +: PPN_W];
          if (lvl_r == sv39_ptw_pkg::LVL_LEAF) begin
            // offset lands in the zero low bits: no carry
            strobe_nxt = 1'b1;
            pa_nxt     = {rd_data_r[sv39_ptw_pkg::PTE_PPN_LSB +: PPN_W],
                          (add_off_r ? va_r[sv39_ptw_pkg::OFF_W-1:0]
                                     : {sv39_ptw_pkg::OFF_W{1'b0}})};
            st_nxt     = sv39_ptw_pkg::ST_OK;
            state_nxt  = S_IDLE;
          end else begin
            lvl_nxt   = lvl_r - 2'd1;
            state_nxt = S_ADDR;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      lvl_r      <= '0;
      cur_ppn_r  <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      lvl_r      <= lvl_nxt;
      cur_ppn_r  <= cur_ppn_nxt;
      strobe_r   <= strobe_nxt;
    end
    va_r <= va_nxt;
    pa_r <= pa_nxt;
    st_r <= st_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_phys_addr = pa_r;
  assign out_status    = st_r;

  // ------------------------------------------------------------------
  // Assertions

  // a result word follows an accept or a cycle of walking
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a preceding item");

  // faults report a zero address
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != sv39_ptw_pkg::ST_OK)) |-> (out_phys_addr == '0))
    else $error("nonzero address on a fault");

  // the store is never written while a walk reads it
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ADDR) || (state_r == S_EVAL)) |-> !mem_we)
    else $error("store written during a walk");

  // a walk that goes on from an entry check steps down one level
  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EVAL) && (state_nxt == S_ADDR)) |=> (lvl_r == $past(lvl_r) - 2'd1))
    else $error("walk level did not step down");

endmodule
